// ===== sv/ccc_pkg.sv =====
// Shared types, constants and the sRGB linearization table function.
package ccc_pkg;

  localparam int unsigned COLOR_W = 24;
  localparam int unsigned NEED_W = 8;
  localparam int unsigned RATIO_W = 12;
  localparam int unsigned WEIGHT_W = 13;
  localparam int unsigned CHAN_N = 6;

  localparam logic [WEIGHT_W-1:0] LUM_WEIGHT [3] = '{13'd2126, 13'd7152, 13'd722};
  localparam logic [WEIGHT_W-1:0] LUM_OFFSET = 13'd500;
  localparam logic [6:0] RATIO_SCALE = 7'd100;
  localparam logic [3:0] NEED_SCALE = 4'd10;

  typedef enum logic [1:0] {
    VERDICT_PASS = 2'd0,
    VERDICT_HARD = 2'd1,
    VERDICT_WARN = 2'd2
  } verdict_t;

  typedef struct packed {
    logic [COLOR_W-1:0] fg_color;
    logic [COLOR_W-1:0] bg_color;
    logic [NEED_W-1:0]  need_tenths;
    logic               advisory;
  } in_word_t;

  typedef struct packed {
    logic [RATIO_W-1:0] ratio_hundredths;
    verdict_t           verdict;
  } out_word_t;

  typedef struct packed {
    logic [NEED_W-1:0] need_tenths;
    logic              advisory;
  } side_t;

  function automatic logic [63:0] mq(input logic [63:0] a, input logic [63:0] b);
    logic [63:0] p;
    p = a * b;
    return p >> 30;
  endfunction

  function automatic logic [63:0] pow5q(input logic [63:0] r);
    logic [63:0] p;
    p = mq(r, r);
    p = mq(p, r);
    p = mq(p, r);
    return mq(p, r);
  endfunction

  // Linear light of one sRGB channel value with frac fraction bits.
  function automatic logic [31:0] lin_entry(input int unsigned idx, input int unsigned frac);
    logic [63:0] num;
    logic [63:0] t;
    logic [63:0] t2;
    logic [63:0] lo;
    logic [63:0] hi;
    logic [63:0] mid;
    logic [63:0] y;
    lo = 64'd0;
    hi = 64'd1 << 30;
    if (64'(idx) * 64'd100000 <= 64'd1001640) begin
      num = ((64'(idx) * 64'd20) << frac) + 64'd32946;
      y = num / 64'd65892;
    end else begin
      t = (64'(40 * idx + 561) << 30) / 64'd10761;
      t2 = mq(t, t);
      for (int k = 0; k < 32; k++) begin
        if (lo < hi) begin
          mid = (lo + hi + 64'd1) >> 1;
          if (pow5q(mid) <= t2) begin
            lo = mid;
          end else begin
            hi = mid - 64'd1;
          end
        end
      end
      y = mq(t2, lo);
      y = (y + (64'd1 << (29 - frac))) >> (30 - frac);
    end
    return y[31:0];
  endfunction

endpackage

// ===== sv/ccc_lum.sv =====
// Four-stage luminance front end: table lookup, weighting, summing, ordering.
module ccc_lum
  import ccc_pkg::*;
#(
  parameter int unsigned LUM_FRAC_BITS = 16
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  in_word_t                  in_data,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [LUM_FRAC_BITS+13:0] out_hi,
  output logic [LUM_FRAC_BITS+13:0] out_lo,
  output side_t                     out_side
);

  localparam int unsigned EW = LUM_FRAC_BITS + 1;
  localparam int unsigned LW = LUM_FRAC_BITS + 14;

  logic [EW-1:0] lin_rom [256];

  for (genvar gi = 0; gi < 256; gi++) begin : g_rom
    assign lin_rom[gi] = EW'(lin_entry(gi, LUM_FRAC_BITS));
  end

  logic [7:0] chan [CHAN_N];
  assign chan[0] = in_data.fg_color[23:16];
  assign chan[1] = in_data.fg_color[15:8];
  assign chan[2] = in_data.fg_color[7:0];
  assign chan[3] = in_data.bg_color[23:16];
  assign chan[4] = in_data.bg_color[15:8];
  assign chan[5] = in_data.bg_color[7:0];

  logic          v1_r, v2_r, v3_r, v4_r;
  logic          rdy1, rdy2, rdy3, rdy4;
  logic [EW-1:0] ent_r [CHAN_N];
  logic [LW-1:0] prod_r [CHAN_N];
  logic [LW-1:0] lum_a_r, lum_b_r;
  logic [LW-1:0] lum_a_nxt, lum_b_nxt;
  logic [LW-1:0] hi_r, lo_r;
  side_t         side1_r, side2_r, side3_r, side4_r;

  assign rdy4 = !v4_r || out_ready;
  assign rdy3 = !v3_r || rdy4;
  assign rdy2 = !v2_r || rdy3;
  assign rdy1 = !v1_r || rdy2;
  assign in_ready = rdy1;

  always_comb begin
    lum_a_nxt = prod_r[0] + prod_r[1] + prod_r[2] + (LW'(LUM_OFFSET) << LUM_FRAC_BITS);
    lum_b_nxt = prod_r[3] + prod_r[4] + prod_r[5] + (LW'(LUM_OFFSET) << LUM_FRAC_BITS);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      if (rdy1) v1_r <= in_valid;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
      if (rdy4) v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1) begin
      for (int k = 0; k < CHAN_N; k++) begin
        ent_r[k] <= lin_rom[chan[k]];
      end
      side1_r <= '{need_tenths: in_data.need_tenths, advisory: in_data.advisory};
    end
    if (rdy2) begin
      for (int k = 0; k < CHAN_N; k++) begin
        prod_r[k] <= LW'(ent_r[k]) * LW'(LUM_WEIGHT[k % 3]);
      end
      side2_r <= side1_r;
    end
    if (rdy3) begin
      lum_a_r <= lum_a_nxt;
      lum_b_r <= lum_b_nxt;
      side3_r <= side2_r;
    end
    if (rdy4) begin
      if (lum_a_r >= lum_b_r) begin
        hi_r <= lum_a_r;
        lo_r <= lum_b_r;
      end else begin
        hi_r <= lum_b_r;
        lo_r <= lum_a_r;
      end
      side4_r <= side3_r;
    end
  end

  assign out_valid = v4_r;
  assign out_hi = hi_r;
  assign out_lo = lo_r;
  assign out_side = side4_r;

endmodule

// ===== sv/ccc_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, carrying the verdict.
module ccc_div
  import ccc_pkg::*;
#(
  parameter int unsigned LUM_FRAC_BITS = 16
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [LUM_FRAC_BITS+20:0] in_num,
  input  logic [LUM_FRAC_BITS+13:0] in_den,
  input  verdict_t                  in_verdict,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [RATIO_W-1:0]        out_quot,
  output verdict_t                  out_verdict
);

  localparam int unsigned LW = LUM_FRAC_BITS + 14;
  localparam int unsigned NW = LUM_FRAC_BITS + 21;
  localparam int unsigned DW = LW + RATIO_W;

  logic [RATIO_W-1:0] v_r;
  logic [RATIO_W:0]   rdy;
  logic [NW-1:0]      rem_r  [RATIO_W];
  logic [LW-1:0]      den_r  [RATIO_W];
  logic [RATIO_W-1:0] quot_r [RATIO_W];
  verdict_t           verd_r [RATIO_W];

  assign rdy[RATIO_W] = out_ready;
  assign in_ready = rdy[0];

  for (genvar j = 0; j < RATIO_W; j++) begin : g_stage
    localparam int unsigned SH = RATIO_W - 1 - j;
    logic               v_in;
    logic [NW-1:0]      rem_in;
    logic [LW-1:0]      den_in;
    logic [RATIO_W-1:0] quot_in;
    verdict_t           verd_in;
    logic [DW-1:0]      den_sh;
    logic               take;

    if (j == 0) begin : g_first
      assign v_in = in_valid;
      assign rem_in = in_num;
      assign den_in = in_den;
      assign quot_in = '0;
      assign verd_in = in_verdict;
    end else begin : g_next
      assign v_in = v_r[j-1];
      assign rem_in = rem_r[j-1];
      assign den_in = den_r[j-1];
      assign quot_in = quot_r[j-1];
      assign verd_in = verd_r[j-1];
    end

    assign rdy[j] = !v_r[j] || rdy[j+1];
    assign den_sh = DW'(den_in) << SH;
    assign take = DW'(rem_in) >= den_sh;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[j] <= 1'b0;
      end else if (rdy[j]) begin
        v_r[j] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (rdy[j]) begin
        rem_r[j] <= take ? NW'(DW'(rem_in) - den_sh) : rem_in;
        den_r[j] <= den_in;
        quot_r[j] <= quot_in | (RATIO_W'(take) << SH);
        verd_r[j] <= verd_in;
      end
    end
  end

  assign out_valid = v_r[RATIO_W-1];
  assign out_quot = quot_r[RATIO_W-1];
  assign out_verdict = verd_r[RATIO_W-1];

endmodule

// ===== sv/color_contrast_checker.sv =====
// Top level of the color contrast checker: luminance front end, verdict stage, divider.
//
// One color pair word enters per cycle unless out_ready stalls the pipeline and passes
// four luminance stages (sRGB table lookup, channel weighting, summing, ordering),
// one stage for the scaled numerator and the pass compare, and a 12-stage restoring
// divider that produces one bit of the ratio in hundredths per stage. Every stage
// holds a word while the next is full, so empty stages keep filling and the input
// stays ready while a finished result waits. The strict_mode register is written
// through the cfg port, which is always ready, and must only change while no word
// is in flight. LUM_FRAC_BITS sets the fraction bits of the linear-light table.
module color_contrast_checker
  import ccc_pkg::*;
#(
  parameter int unsigned LUM_FRAC_BITS = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_word_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_word_t out_data,
  input  logic      cfg_valid,
  output logic      cfg_ready,
  input  logic      cfg_data
);

  localparam int unsigned LW = LUM_FRAC_BITS + 14;
  localparam int unsigned NW = LUM_FRAC_BITS + 21;
  localparam int unsigned CW = LW + NEED_W;

  logic          strict_r;
  logic          lum_valid, lum_ready;
  logic [LW-1:0] lum_hi, lum_lo;
  side_t         lum_side;

  logic          v5_r, rdy5, div_ready;
  logic [NW-1:0] num_r;
  logic [LW-1:0] den_r;
  verdict_t      verd_r, verd_nxt;
  logic [CW-1:0] lhs, rhs;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      strict_r <= 1'b0;
    end else if (cfg_valid) begin
      strict_r <= cfg_data;
    end
  end

  ccc_lum #(
    .LUM_FRAC_BITS(LUM_FRAC_BITS)
  ) u_lum (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(lum_valid),
    .out_ready(lum_ready),
    .out_hi   (lum_hi),
    .out_lo   (lum_lo),
    .out_side (lum_side)
  );

  assign rdy5 = !v5_r || div_ready;
  assign lum_ready = rdy5;

  always_comb begin
    lhs = CW'(lum_hi) * CW'(NEED_SCALE);
    rhs = CW'(lum_lo) * CW'(lum_side.need_tenths);
    priority if (lhs >= rhs) begin
      verd_nxt = VERDICT_PASS;
    end else if (!lum_side.advisory || strict_r) begin
      verd_nxt = VERDICT_HARD;
    end else begin
      verd_nxt = VERDICT_WARN;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v5_r <= 1'b0;
    end else if (rdy5) begin
      v5_r <= lum_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy5) begin
      num_r <= NW'(lum_hi) * NW'(RATIO_SCALE);
      den_r <= lum_lo;
      verd_r <= verd_nxt;
    end
  end

  ccc_div #(
    .LUM_FRAC_BITS(LUM_FRAC_BITS)
  ) u_div (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (v5_r),
    .in_ready   (div_ready),
    .in_num     (num_r),
    .in_den     (den_r),
    .in_verdict (verd_r),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_quot   (out_data.ratio_hundredths),
    .out_verdict(out_data.verdict)
  );

endmodule
